// ===== rtl/core/stepper_homing_speed_ramp_unit_assert.svh =====
// Assertion macros shared by the stepper homing speed ramp RTL.
`ifndef STEPPER_HOMING_SPEED_RAMP_UNIT_ASSERT_SVH
`define STEPPER_HOMING_SPEED_RAMP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define SHRSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shrsu assertion failed");
// Next-cycle implication, checked out of reset.
`define SHRSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shrsu assertion failed");
`else
`define SHRSU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHRSU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/shrsu_pkg.sv =====
// Shared types, constants and the step period table of the speed ramp unit.
package shrsu_pkg;

    // Register index, taken from the word address bit of the config port
    typedef enum logic {
        REG_IDLE_CURRENT   = 1'b0,
        REG_MOVING_CURRENT = 1'b1
    } t_reg_idx;

    localparam logic [6:0] IDLE_CURRENT_RESET   = 7'd15;
    localparam logic [6:0] MOVING_CURRENT_RESET = 7'd40;

    localparam logic signed [7:0] SPEED_HOMING = 8'sd15;
    localparam int SPEED_MAX  = 100;
    localparam int SPEED_STEP = 2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic calc_diff;
        logic update;
        logic load_out;
    } t_cmd;

    // Next step interval: 100000 / (400 + 26 * mag) for mag 0..100
    function automatic logic [7:0] step_period(input logic [6:0] mag);
        logic [7:0] p;
        case (mag)
            7'd0: p = 8'd250;   7'd1: p = 8'd234;   7'd2: p = 8'd221;
            7'd3: p = 8'd209;   7'd4: p = 8'd198;   7'd5: p = 8'd188;
            7'd6: p = 8'd179;   7'd7: p = 8'd171;   7'd8: p = 8'd164;
            7'd9: p = 8'd157;   7'd10: p = 8'd151;  7'd11: p = 8'd145;
            7'd12: p = 8'd140;  7'd13: p = 8'd135;  7'd14: p = 8'd130;
            7'd15: p = 8'd126;  7'd16: p = 8'd122;  7'd17: p = 8'd118;
            7'd18: p = 8'd115;  7'd19: p = 8'd111;  7'd20: p = 8'd108;
            7'd21: p = 8'd105;  7'd22: p = 8'd102;  7'd23: p = 8'd100;
            7'd24: p = 8'd97;   7'd25: p = 8'd95;   7'd26: p = 8'd92;
            7'd27: p = 8'd90;   7'd28: p = 8'd88;   7'd29: p = 8'd86;
            7'd30: p = 8'd84;   7'd31: p = 8'd82;   7'd32: p = 8'd81;
            7'd33: p = 8'd79;   7'd34: p = 8'd77;   7'd35: p = 8'd76;
            7'd36: p = 8'd74;   7'd37: p = 8'd73;   7'd38: p = 8'd72;
            7'd39: p = 8'd70;   7'd40: p = 8'd69;   7'd41: p = 8'd68;
            7'd42: p = 8'd67;   7'd43: p = 8'd65;   7'd44: p = 8'd64;
            7'd45: p = 8'd63;   7'd46: p = 8'd62;   7'd47: p = 8'd61;
            7'd48: p = 8'd60;   7'd49: p = 8'd59;   7'd50: p = 8'd58;
            7'd51: p = 8'd57;   7'd52: p = 8'd57;   7'd53: p = 8'd56;
            7'd54: p = 8'd55;   7'd55: p = 8'd54;   7'd56: p = 8'd53;
            7'd57: p = 8'd53;   7'd58: p = 8'd52;   7'd59: p = 8'd51;
            7'd60: p = 8'd51;   7'd61: p = 8'd50;   7'd62: p = 8'd49;
            7'd63: p = 8'd49;   7'd64: p = 8'd48;   7'd65: p = 8'd47;
            7'd66: p = 8'd47;   7'd67: p = 8'd46;   7'd68: p = 8'd46;
            7'd69: p = 8'd45;   7'd70: p = 8'd45;   7'd71: p = 8'd44;
            7'd72: p = 8'd44;   7'd73: p = 8'd43;   7'd74: p = 8'd43;
            7'd75: p = 8'd42;   7'd76: p = 8'd42;   7'd77: p = 8'd41;
            7'd78: p = 8'd41;   7'd79: p = 8'd40;   7'd80: p = 8'd40;
            7'd81: p = 8'd39;   7'd82: p = 8'd39;   7'd83: p = 8'd39;
            7'd84: p = 8'd38;   7'd85: p = 8'd38;   7'd86: p = 8'd37;
            7'd87: p = 8'd37;   7'd88: p = 8'd37;   7'd89: p = 8'd36;
            7'd90: p = 8'd36;   7'd91: p = 8'd36;   7'd92: p = 8'd35;
            7'd93: p = 8'd35;   7'd94: p = 8'd35;   7'd95: p = 8'd34;
            7'd96: p = 8'd34;   7'd97: p = 8'd34;   7'd98: p = 8'd33;
            7'd99: p = 8'd33;   7'd100: p = 8'd33;
            default: p = 8'd33;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/shrsu_ctrl.sv =====
// Sequencing state machine of the speed ramp unit.
`include "stepper_homing_speed_ramp_unit_assert.svh"
module shrsu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output shrsu_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_UPDATE,
        ST_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Result register is free when empty or drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.calc_diff = 1'b1;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Set valid on load, drop it on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SHRSU_ASSERT_IMP(a_load_only_when_free, i_clk, i_rst_n, o_cmd.load_out, w_out_free)
    `SHRSU_ASSERT_NXT(a_accept_starts_item, i_clk, i_rst_n, i_in_valid && o_in_ready,
                      o_cmd.calc_diff)
    `SHRSU_ASSERT_NXT(a_update_then_load, i_clk, i_rst_n, o_cmd.update, r_state == ST_LOAD)

endmodule

// ===== rtl/core/shrsu_dp.sv =====
// Datapath of the speed ramp unit: axis state, ramp, stepping and period lookup.
`include "stepper_homing_speed_ramp_unit_assert.svh"
module shrsu_dp #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shrsu_pkg::t_cmd      i_cmd,
    input  logic [6:0]           i_idle_current,
    input  logic [6:0]           i_moving_current,
    input  logic                 i_action,
    input  logic                 i_optical_level,
    input  logic signed [15:0]   i_target_position,
    output logic                 o_step_pulse,
    output logic                 o_direction,
    output logic signed [15:0]   o_position,
    output logic signed [7:0]    o_speed,
    output logic [6:0]           o_drive_current,
    output logic                 o_homed,
    output logic [7:0]           o_step_period
);

    localparam int PB = POSITION_BITS;
    localparam int EW = (PB > 16) ? PB : 16;
    localparam int DW = EW + 1;
    localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};
    localparam logic signed [DW-1:0] C_STEP = DW'(shrsu_pkg::SPEED_STEP);
    localparam logic signed [DW-1:0] C_MAX = DW'(shrsu_pkg::SPEED_MAX);
    localparam logic signed [DW-1:0] C_MIN = -DW'(shrsu_pkg::SPEED_MAX);

    // Captured item
    logic                 r_action;
    logic                 r_opt;
    logic signed [15:0]   r_target;
    logic signed [DW-1:0] r_diff;

    // Axis state
    logic signed [7:0]    r_speed, n_speed;
    logic signed [PB-1:0] r_pos, n_pos;
    logic                 r_homed, n_homed;
    logic                 r_last_opt;
    logic [6:0]           r_current, n_current;
    logic                 r_dir, n_dir;
    logic                 r_pulse, n_pulse;

    // Result register
    logic                 r_o_pulse;
    logic                 r_o_dir;
    logic signed [15:0]   r_o_pos;
    logic signed [7:0]    r_o_speed;
    logic [6:0]           r_o_current;
    logic                 r_o_homed;
    logic [7:0]           r_o_period;

    logic signed [DW-1:0] w_adj;
    logic signed [DW-1:0] w_half;
    logic signed [DW-1:0] w_sp;
    logic signed [DW-1:0] w_rup;
    logic signed [DW-1:0] w_rdn;
    logic signed [EW-1:0] w_pos_ext;
    logic signed [7:0]    w_neg_speed;
    logic [6:0]           w_mag;

    // Halve the distance, rounding toward zero
    assign w_adj = r_diff + $signed({{(DW-1){1'b0}}, r_diff[DW-1]});
    assign w_half = w_adj >>> 1;
    assign w_sp = DW'(r_speed);

    // Ramp up toward a target ahead
    always_comb begin
        w_rup = w_sp + C_STEP;
        if (w_half < w_rup) begin
            w_rup = w_half;
        end
        if (w_rup > C_MAX) begin
            w_rup = C_MAX;
        end
        if (w_rup == '0) begin
            w_rup = C_STEP;
        end
    end

    // Ramp down toward a target behind
    always_comb begin
        w_rdn = w_sp - C_STEP;
        if (w_half > w_rdn) begin
            w_rdn = w_half;
        end
        if (w_rdn < C_MIN) begin
            w_rdn = C_MIN;
        end
        if (w_rdn == '0) begin
            w_rdn = -C_STEP;
        end
    end

    // Next axis state for a control or step tick
    always_comb begin
        n_speed = r_speed;
        n_pos = r_pos;
        n_homed = r_homed;
        n_current = r_current;
        n_dir = r_dir;
        n_pulse = 1'b0;
        if (!r_action) begin
            if (!r_homed) begin
                n_speed = shrsu_pkg::SPEED_HOMING;
            end else if (r_diff != '0) begin
                n_current = i_moving_current;
                n_speed = r_diff[DW-1] ? w_rdn[7:0] : w_rup[7:0];
            end else begin
                n_speed = '0;
                if (i_idle_current > r_current) begin
                    n_current = i_idle_current;
                end else if (i_idle_current < r_current) begin
                    n_current = r_current - 7'd1;
                end
            end
            // Zero on a rising sensor edge while moving forward
            if (!n_speed[7] && (n_speed != '0) && !r_last_opt && r_opt) begin
                n_pos = '0;
                n_homed = 1'b1;
            end
        end else if (r_speed != '0) begin
            n_pulse = 1'b1;
            n_dir = r_speed[7];
            if (!r_speed[7]) begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + PB'(1);
                end
            end else if (r_pos != POS_MIN) begin
                n_pos = r_pos - PB'(1);
            end
        end
    end

    // Capture the item and the distance to target
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_opt <= i_optical_level;
            r_target <= i_target_position;
        end
        if (i_cmd.calc_diff) begin
            r_diff <= DW'(r_target) - DW'(r_pos);
        end
    end

    // Commit axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_pos <= '0;
            r_homed <= 1'b0;
            r_last_opt <= 1'b0;
            r_current <= shrsu_pkg::IDLE_CURRENT_RESET;
            r_dir <= 1'b0;
            r_pulse <= 1'b0;
        end else if (i_cmd.update) begin
            r_speed <= n_speed;
            r_pos <= n_pos;
            r_homed <= n_homed;
            r_current <= n_current;
            r_dir <= n_dir;
            r_pulse <= n_pulse;
            if (!r_action) begin
                r_last_opt <= r_opt;
            end
        end
    end

    // Look up the period and load the result register
    assign w_pos_ext = EW'(r_pos);
    assign w_neg_speed = -r_speed;
    assign w_mag = r_speed[7] ? w_neg_speed[6:0] : r_speed[6:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_pulse <= r_pulse;
            r_o_dir <= r_dir;
            r_o_pos <= w_pos_ext[15:0];
            r_o_speed <= r_speed;
            r_o_current <= r_current;
            r_o_homed <= r_homed;
            r_o_period <= shrsu_pkg::step_period(w_mag);
        end
    end

    assign o_step_pulse = r_o_pulse;
    assign o_direction = r_o_dir;
    assign o_position = r_o_pos;
    assign o_speed = r_o_speed;
    assign o_drive_current = r_o_current;
    assign o_homed = r_o_homed;
    assign o_step_period = r_o_period;

    `SHRSU_ASSERT_IMP(a_speed_in_range, i_clk, i_rst_n, 1'b1,
                      (r_speed <= 8'sd100) && (r_speed >= -8'sd100))
    `SHRSU_ASSERT_NXT(a_homed_sticks, i_clk, i_rst_n, r_homed, r_homed)
    `SHRSU_ASSERT_NXT(a_step_follows_speed, i_clk, i_rst_n,
                      i_cmd.update && r_action && (r_speed != '0),
                      r_pulse && (r_speed[7] == r_dir))

endmodule

// ===== rtl/core/stepper_homing_speed_ramp_unit.sv =====
// Top level of the stepper homing speed ramp unit: config registers and core.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick: i_action selects a
//   control tick (0, uses i_optical_level and i_target_position) or a step tick (1).
//   Output channel (o_out_valid / i_out_ready) returns one result per tick: step
//   pulse, direction, position, speed, drive current, homed flag and the next
//   step period in 10 us timer ticks.
//   A transferred tick runs through the four-step sequencer (capture, distance
//   subtract, state update, period lookup into the result) before its result
//   shows; a new tick is taken only after the previous one has left the lookup step.
//   A stalled receiver holds the result register; the next tick is still taken
//   and runs up to the lookup step, where it waits until the result drains.
//   Config: APB-style port, pready tied high, idle current at 0x0 and moving current
//   at 0x4, which the user must write only while no tick is in flight; not enforced.
//   Reset (synchronous, active low) clears speed, position, homed and sensor
//   history, sets the drive current to 15 and the registers to 15 and 40.
module stepper_homing_speed_ramp_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic                 i_optical_level,
    input  logic signed [15:0]   i_target_position,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_step_pulse,
    output logic                 o_direction,
    output logic signed [15:0]   o_position,
    output logic signed [7:0]    o_speed,
    output logic [6:0]           o_drive_current,
    output logic                 o_homed,
    output logic [7:0]           o_step_period
);

    logic [6:0]      r_idle_current;
    logic [6:0]      r_moving_current;
    logic            w_cfg_write;
    shrsu_pkg::t_cmd w_cmd;

    assign pready = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    // Write the current registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_current <= shrsu_pkg::IDLE_CURRENT_RESET;
            r_moving_current <= shrsu_pkg::MOVING_CURRENT_RESET;
        end else if (w_cfg_write) begin
            case (shrsu_pkg::t_reg_idx'(paddr[2]))
                shrsu_pkg::REG_IDLE_CURRENT: r_idle_current <= pwdata[6:0];
                shrsu_pkg::REG_MOVING_CURRENT: r_moving_current <= pwdata[6:0];
                default: r_idle_current <= r_idle_current;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (shrsu_pkg::t_reg_idx'(paddr[2]))
            shrsu_pkg::REG_IDLE_CURRENT: prdata = {25'd0, r_idle_current};
            shrsu_pkg::REG_MOVING_CURRENT: prdata = {25'd0, r_moving_current};
            default: prdata = '0;
        endcase
    end

    shrsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    shrsu_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_idle_current    (r_idle_current),
        .i_moving_current  (r_moving_current),
        .i_action          (i_action),
        .i_optical_level   (i_optical_level),
        .i_target_position (i_target_position),
        .o_step_pulse      (o_step_pulse),
        .o_direction       (o_direction),
        .o_position        (o_position),
        .o_speed           (o_speed),
        .o_drive_current   (o_drive_current),
        .o_homed           (o_homed),
        .o_step_period     (o_step_period)
    );

endmodule
